FILE: hdl/sum_checked_frame_receiver_top_macros.svh
// Assertion helpers for the checker file.
`ifndef SUM_CHECKED_FRAME_RECEIVER_TOP_MACROS_SVH
`define SUM_CHECKED_FRAME_RECEIVER_TOP_MACROS_SVH

// Clocked assertion, inactive while reset is asserted
`define SCF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("scf assertion failed");

// Clocked assertion that is also checked during reset
`define SCF_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("scf reset assertion failed");

`endif

FILE: hdl/scf_pkg.sv
package scf_pkg;

  // Frame geometry
  localparam int FrameBytes = 32;
  localparam int StoreDepth = FrameBytes - 5;
  localparam int BufDepth   = 2 * StoreDepth;
  localparam int BufAw      = $clog2(BufDepth);
  localparam int LenW       = $clog2(StoreDepth + 1);
  localparam int PosW       = $clog2(FrameBytes);
  localparam int FlenW      = 6;
  localparam int OutDataW   = 24;

  // Header bytes
  localparam logic [7:0] HdrFirst  = 8'hAA;
  localparam logic [7:0] HdrSecond = 8'hAF;

  // One checked frame waiting to be sent out
  typedef struct packed {
    logic [7:0]      cmd;
    logic [LenW-1:0] len;
    logic [7:0]      csum;
  } desc_t;

  // Frame queue status
  typedef struct packed {
    logic full;
    logic empty;
    logic wr_ptr;
    logic rd_ptr;
  } q_status_t;

endpackage

FILE: hdl/scf_buf.sv
// Two-bank payload buffer: one write port, one registered read port.
module scf_buf (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [scf_pkg::BufAw-1:0] waddr_i,
  input  logic [7:0]              wdata_i,
  input  logic [scf_pkg::BufAw-1:0] raddr_i,
  output logic [7:0]              rdata_o
);
  import scf_pkg::*;

  logic [7:0] mem [BufDepth];
  logic [7:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/scf_queue.sv
// Two-entry queue of checked frames; entry slot also selects the buffer bank.
module scf_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  scf_pkg::desc_t     desc_i,
  input  logic               pop_i,
  output scf_pkg::desc_t     head_o,
  output scf_pkg::q_status_t status_o
);
  import scf_pkg::*;

  desc_t      slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // descriptor storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= desc_i;
    end
  end

  assign head_o          = slot_q[rd_ptr_q];
  assign status_o.full   = cnt_q[1];
  assign status_o.empty  = (cnt_q == 2'd0);
  assign status_o.wr_ptr = wr_ptr_q;
  assign status_o.rd_ptr = rd_ptr_q;

endmodule

FILE: hdl/scf_front.sv
// Frame parser: hunts for the header, checks the sum, stores the payload.
module scf_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,
  input  scf_pkg::q_status_t        q_status_i,
  output logic                      push_o,
  output scf_pkg::desc_t            desc_o,
  output logic                      we_o,
  output logic [scf_pkg::BufAw-1:0] waddr_o,
  output logic [7:0]                wdata_o
);
  import scf_pkg::*;

  localparam logic [2:0] PhHunt   = 3'd0;
  localparam logic [2:0] PhSecond = 3'd1;
  localparam logic [2:0] PhCmd    = 3'd2;
  localparam logic [2:0] PhLen    = 3'd3;
  localparam logic [2:0] PhData   = 3'd4;
  localparam logic [2:0] PhSum    = 3'd5;

  logic [2:0]      phase_q, phase_d;
  logic [7:0]      cmd_q, cmd_d;
  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] cnt_q, cnt_d;
  logic [7:0]      sum_q, sum_d;
  logic            xfer;
  logic [7:0]      b;
  logic [LenW-1:0] cnt_inc;

  // a free bank exists whenever the queue has room
  assign s_axis_tready = !q_status_i.full;
  assign xfer          = s_axis_tvalid && s_axis_tready;
  assign b             = s_axis_tdata;
  assign cnt_inc       = cnt_q + LenW'(1);

  // parse step
  always_comb begin
    phase_d = phase_q;
    cmd_d   = cmd_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    push_o  = 1'b0;
    we_o    = 1'b0;
    if (xfer) begin
      unique case (phase_q)
        PhSecond: begin
          if (b == HdrSecond) begin
            sum_d   = sum_q + b;
            phase_d = PhCmd;
          end else begin
            phase_d = PhHunt;
          end
        end
        PhCmd: begin
          cmd_d   = b;
          sum_d   = sum_q + b;
          phase_d = PhLen;
        end
        PhLen: begin
          sum_d = sum_q + b;
          len_d = b[LenW-1:0];
          cnt_d = '0;
          if (b > 8'(StoreDepth)) begin
            phase_d = PhHunt;
          end else if (b == 8'd0) begin
            phase_d = PhSum;
          end else begin
            phase_d = PhData;
          end
        end
        PhData: begin
          we_o  = 1'b1;
          cnt_d = cnt_inc;
          sum_d = sum_q + b;
          if (cnt_inc >= len_q) begin
            phase_d = PhSum;
          end
        end
        PhSum: begin
          push_o  = (b == sum_q);
          phase_d = PhHunt;
        end
        default: begin
          // hunting; unused codes hunt too
          if (b == HdrFirst) begin
            sum_d   = b;
            phase_d = PhSecond;
          end else begin
            phase_d = PhHunt;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      cmd_q   <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
      sum_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
    end
  end

  // payload goes to the bank of the queue slot being filled
  assign waddr_o = q_status_i.wr_ptr ? BufAw'(StoreDepth) + BufAw'(cnt_q) : BufAw'(cnt_q);
  assign wdata_o = b;

  assign desc_o.cmd  = cmd_q;
  assign desc_o.len  = len_q;
  assign desc_o.csum = b;

endmodule

FILE: hdl/scf_back.sv
// Frame sender: replays one queued frame byte by byte into the output register.
module scf_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  scf_pkg::desc_t               head_i,
  input  scf_pkg::q_status_t           q_status_i,
  output logic                         pop_o,
  output logic [scf_pkg::BufAw-1:0]    raddr_o,
  input  logic [7:0]                   rdata_i,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [scf_pkg::OutDataW-1:0] m_axis_tdata,   // [7:0] command, [13:8] frame_length,
                                                       // [21:14] frame_byte, [23:22] zero
  output logic                         m_axis_tlast    // last_byte
);
  import scf_pkg::*;

  logic [PosW-1:0]  pos_q, pos_d;
  logic             wait_q, wait_d;
  logic             vld_q, vld_d;
  logic [7:0]       cmd_q, cmd_d;
  logic [FlenW-1:0] flen_q, flen_d;
  logic [7:0]       byte_q, byte_d;
  logic             last_q, last_d;
  logic             out_free;
  logic             is_pay;
  logic [PosW:0]    last_idx;
  logic [LenW-1:0]  pay_idx;
  logic [7:0]       fixed_byte;

  assign out_free = !vld_q || m_axis_tready;
  assign last_idx = (PosW+1)'(head_i.len) + (PosW+1)'(4);
  assign is_pay   = (pos_q >= PosW'(4)) && ((PosW+1)'(pos_q) < last_idx);
  assign pay_idx  = is_pay ? LenW'(pos_q - PosW'(4)) : '0;
  assign raddr_o  = q_status_i.rd_ptr ? BufAw'(StoreDepth) + BufAw'(pay_idx) : BufAw'(pay_idx);

  // bytes that do not come from the buffer
  always_comb begin
    priority if (pos_q == PosW'(0)) begin
      fixed_byte = HdrFirst;
    end else if (pos_q == PosW'(1)) begin
      fixed_byte = HdrSecond;
    end else if (pos_q == PosW'(2)) begin
      fixed_byte = head_i.cmd;
    end else if (pos_q == PosW'(3)) begin
      fixed_byte = 8'(head_i.len);
    end else begin
      fixed_byte = head_i.csum;
    end
  end

  // sequencing of the output register
  always_comb begin
    pos_d  = pos_q;
    wait_d = wait_q;
    vld_d  = vld_q;
    cmd_d  = cmd_q;
    flen_d = flen_q;
    byte_d = byte_q;
    last_d = last_q;
    pop_o  = 1'b0;
    if (vld_q && m_axis_tready) begin
      vld_d = 1'b0;
    end
    if (!q_status_i.empty && out_free) begin
      if (is_pay && !wait_q) begin
        // read issued, data is back next cycle
        wait_d = 1'b1;
      end else begin
        vld_d  = 1'b1;
        cmd_d  = head_i.cmd;
        flen_d = FlenW'(head_i.len) + FlenW'(5);
        byte_d = is_pay ? rdata_i : fixed_byte;
        wait_d = 1'b0;
        if ((PosW+1)'(pos_q) == last_idx) begin
          last_d = 1'b1;
          pos_d  = '0;
          pop_o  = 1'b1;
        end else begin
          last_d = 1'b0;
          pos_d  = pos_q + PosW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      wait_q <= 1'b0;
      vld_q  <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      wait_q <= wait_d;
      vld_q  <= vld_d;
    end
  end

  // payload of the output register
  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    flen_q <= flen_d;
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = {2'b00, byte_q, flen_q, cmd_q};
  assign m_axis_tlast  = last_q;

endmodule

FILE: hdl/sum_checked_frame_receiver_top.sv
// Input: one byte per cycle while the frame queue has room; stalls only when two
//   checked frames are still waiting to be sent.
// Output: header, command, length and checksum at one per cycle while the output is accepted;
//   each payload byte first waits for its buffer read.
// Reset (async, active low) clears parser, queue and output control; the buffer is not cleared.
module sum_checked_frame_receiver_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // [7:0] rx_byte
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [scf_pkg::OutDataW-1:0] m_axis_tdata,   // [7:0] command, [13:8] frame_length,
                                                       // [21:14] frame_byte, [23:22] zero
  output logic                         m_axis_tlast    // last_byte
);
  import scf_pkg::*;

  q_status_t        q_status;
  desc_t            push_desc;
  desc_t            head_desc;
  logic             push;
  logic             pop;
  logic             we;
  logic [BufAw-1:0] waddr;
  logic [7:0]       wdata;
  logic [BufAw-1:0] raddr;
  logic [7:0]       rdata;

  scf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_status_i    (q_status),
    .push_o        (push),
    .desc_o        (push_desc),
    .we_o          (we),
    .waddr_o       (waddr),
    .wdata_o       (wdata)
  );

  scf_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .desc_i   (push_desc),
    .pop_i    (pop),
    .head_o   (head_desc),
    .status_o (q_status)
  );

  scf_buf u_buf (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  scf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head_desc),
    .q_status_i    (q_status),
    .pop_o         (pop),
    .raddr_o       (raddr),
    .rdata_i       (rdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

FILE: hdl/scf_checker.sv
`include "sum_checked_frame_receiver_top_macros.svh"

// Port-level checks on the frame receiver.
module scf_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic [7:0]                   s_axis_tdata,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [scf_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                         m_axis_tlast
);
  import scf_pkg::*;

  // output stays put while stalled
  `SCF_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
  // frame length is always a legal total
  `SCF_ASSERT(a_flen_range, m_axis_tvalid |-> m_axis_tdata[13:8] >= 6'd5 && m_axis_tdata[13:8] <= 6'(FrameBytes))
  // command and length do not change inside a run
  `SCF_ASSERT(a_run_const, m_axis_tvalid && m_axis_tready && !m_axis_tlast ##1 m_axis_tvalid |-> $stable(m_axis_tdata[13:0]))
  // no output during reset
  `SCF_ASSERT_RST(a_rst_idle, !rst_ni |-> !m_axis_tvalid)

endmodule

bind sum_checked_frame_receiver_top scf_checker u_scf_checker (.*);
